// ===== design/ppmrc_pkg.sv =====
// constants and helpers for the ppm rc frame decoder
`timescale 1ns / 1ps

package ppmrc_pkg;

   localparam int NUM_CHANNELS = 8;

   localparam int TIME_W  = 16;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 4;
   localparam int VALUE_W = 12;

   localparam int RSP_BITS   = INDEX_W + 5 * VALUE_W + 3;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [TIME_W-1:0]  THRESHOLD_RESET = 16'd20000;
   localparam logic [VALUE_W-1:0] VALUE_MAX       = 12'd4095;
   localparam logic [VALUE_W-1:0] THROTTLE_LIMIT  = 12'd2020;
   localparam logic [VALUE_W-1:0] HOLD_THROTTLE   = 12'd1550;
   localparam logic [VALUE_W-1:0] NORMAL_LO       = 12'd950;
   localparam logic [VALUE_W-1:0] NORMAL_HI       = 12'd1050;
   localparam logic [VALUE_W-1:0] HOLD_LO         = 12'd1150;
   localparam logic [VALUE_W-1:0] HOLD_HI         = 12'd1250;
   localparam logic [VALUE_W-1:0] SWITCH_ON       = 12'd1300;
   localparam logic [VALUE_W-1:0] ARM_THROTTLE_MAX = 12'd1100;

   // channel roles
   localparam logic [INDEX_W-1:0] CH_ROLL     = 3'd0;
   localparam logic [INDEX_W-1:0] CH_PITCH    = 3'd1;
   localparam logic [INDEX_W-1:0] CH_THROTTLE = 3'd2;
   localparam logic [INDEX_W-1:0] CH_YAW      = 3'd3;
   localparam logic [INDEX_W-1:0] CH_MODE     = 3'd4;
   localparam logic [INDEX_W-1:0] CH_UNLOCK   = 3'd5;
   localparam logic [INDEX_W-1:0] CH_HEADLESS = 3'd6;

   // reciprocal of six, exact for any 16-bit interval
   localparam logic [TIME_W-1:0] RECIP6 = 16'd43691;
   localparam int RECIP6_SHIFT = 18;

   // interval / 6, saturated to the channel value width
   function automatic logic [VALUE_W-1:0] div6_sat(input logic [TIME_W-1:0] x);
      logic [2*TIME_W-1:0] prod;
      logic [2*TIME_W-RECIP6_SHIFT-1:0] quot;
      prod = (2*TIME_W)'(x) * (2*TIME_W)'(RECIP6);
      quot = prod[2*TIME_W-1:RECIP6_SHIFT];
      if (quot > {{(2*TIME_W-RECIP6_SHIFT-VALUE_W){1'b0}}, VALUE_MAX})
         return VALUE_MAX;
      return quot[VALUE_W-1:0];
   endfunction

endpackage

// ===== design/ppm_rc_frame_decoder_unit.sv =====
// ppm rc frame decoder: edge timestamps in, decoded channels and flight commands out
`timescale 1ns / 1ps

// usage
//  req_*: one word per rising ppm edge, tdata holds the captured timer value
//  csr_*: writes the 16-bit sync threshold, csr_ready is always high;
//         write it only while no word is in flight
//  rsp_*: one word per decoded channel, tlast marks the last channel of a
//         frame; edges that only store a time or mark a frame start give no word
//  path: an edge word taken at a clock edge sits in the input register,
//  is decoded from it when the output can move on, and its channel word
//  is held in the result register until rsp_tready takes it
//  throughput: one edge word per cycle unless stalled; the divide by six
//  (reciprocal multiply), band compares and command update are combinational
//  stall: while rsp_tready is low and a result is held, decode waits and
//  req_tready drops once the input register is full; nothing is lost or
//  repeated
//  reset: synchronous, active high; clears channel state and command
//  registers, sets the sync threshold to 20000 and empties both registers
module ppm_rc_frame_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // capture_time[15:0]
   input  logic [ppmrc_pkg::TIME_W-1:0]      req_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppmrc_pkg::TIME_W-1:0]      csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // channel_index[2:0], channel_value[14:3], roll_out[26:15], pitch_out[38:27],
   // throttle_out[50:39], yaw_out[62:51], armed[63], headless[64],
   // altitude_hold[65], zero fill[71:66]
   output logic [ppmrc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // frame_done
   output logic                              rsp_tlast
);
   import ppmrc_pkg::*;

   logic [TIME_W-1:0]  thr_ff;
   logic               in_valid_ff;
   logic [TIME_W-1:0]  in_time_ff;

   logic               have_prev_ff, have_prev_in;
   logic               sync_ff, sync_in;
   logic [TIME_W-1:0]  prev_ff, prev_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VALUE_W-1:0] roll_ff, roll_in;
   logic [VALUE_W-1:0] pitch_ff, pitch_in;
   logic [VALUE_W-1:0] throttle_ff, throttle_in;
   logic [VALUE_W-1:0] yaw_ff, yaw_in;
   logic               unlock_ff, unlock_in;
   logic               headless_ff, headless_in;
   logic               mode_ff, mode_in;

   logic                  rsp_valid_ff;
   logic [RSP_BITS-1:0]   rsp_data_ff;
   logic                  rsp_last_ff;

   logic               out_free;
   logic               fire;
   logic               emit;
   logic               done;
   logic [TIME_W-1:0]  interval;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] count_next;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign interval   = in_time_ff - prev_ff;
   assign value      = div6_sat(interval);
   assign count_next = count_ff + COUNT_W'(1);

   always_comb begin
      have_prev_in = have_prev_ff;
      sync_in      = sync_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      throttle_in  = throttle_ff;
      yaw_in       = yaw_ff;
      unlock_in    = unlock_ff;
      headless_in  = headless_ff;
      mode_in      = mode_ff;
      emit         = 1'b0;
      done         = 1'b0;
      if (fire) begin
         prev_in = in_time_ff;
         if (!have_prev_ff) begin
            have_prev_in = 1'b1;
         end else begin
            sync_in = sync_ff || (interval >= thr_ff);
            emit    = sync_in && (interval <= thr_ff);
         end
      end
      if (emit) begin
         unique case (count_ff[INDEX_W-1:0])
            CH_ROLL:  roll_in  = value;
            CH_PITCH: pitch_in = value;
            CH_THROTTLE: begin
               if (value < THROTTLE_LIMIT)
                  throttle_in = mode_ff ? HOLD_THROTTLE : value;
            end
            CH_YAW:   yaw_in   = value;
            CH_MODE: begin
               if (value >= NORMAL_LO && value <= NORMAL_HI)
                  mode_in = 1'b0;
               if (value >= HOLD_LO && value <= HOLD_HI) begin
                  mode_in   = 1'b1;
                  unlock_in = 1'b1;
               end
            end
            CH_UNLOCK: begin
               if (value > SWITCH_ON) begin
                  if (throttle_ff < ARM_THROTTLE_MAX)
                     unlock_in = 1'b1;
               end else begin
                  unlock_in = 1'b0;
               end
            end
            CH_HEADLESS: headless_in = (value > SWITCH_ON);
            default: ;
         endcase
         count_in = count_next;
         done     = (count_next >= COUNT_W'(NUM_CHANNELS));
         if (done) begin
            count_in     = '0;
            prev_in      = '0;
            have_prev_in = 1'b0;
            sync_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         in_valid_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         sync_ff      <= 1'b0;
         prev_ff      <= '0;
         count_ff     <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         throttle_ff  <= '0;
         yaw_ff       <= '0;
         unlock_ff    <= 1'b0;
         headless_ff  <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid)
            thr_ff <= csr_data;
         if (req_tready)
            in_valid_ff <= req_tvalid;
         have_prev_ff <= have_prev_in;
         sync_ff      <= sync_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         throttle_ff  <= throttle_in;
         yaw_ff       <= yaw_in;
         unlock_ff    <= unlock_in;
         headless_ff  <= headless_in;
         mode_ff      <= mode_in;
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid)
         in_time_ff <= req_tdata;
      if (emit) begin
         rsp_data_ff <= {mode_in, headless_in, unlock_in, yaw_in, throttle_in,
                         pitch_in, roll_in, value, count_ff[INDEX_W-1:0]};
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== test/ppm_rc_frame_decoder_unit_test.sv =====
// self-checking testbench for the ppm rc frame decoder unit
`timescale 1ns / 1ps

module ppm_rc_frame_decoder_unit_test;
   import ppmrc_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int NUM_PHASES     = 6;

   typedef struct packed {
      logic [INDEX_W-1:0] chan;
      logic [VALUE_W-1:0] value;
      logic               done;
      logic [VALUE_W-1:0] roll;
      logic [VALUE_W-1:0] pitch;
      logic [VALUE_W-1:0] throttle;
      logic [VALUE_W-1:0] yaw;
      logic               armed;
      logic               headless;
      logic               hold;
   } channel_word_type;

   class ppm_scoreboard_type;
      logic [TIME_W-1:0]  threshold;
      bit                 have_prev;
      bit                 synced;
      logic [TIME_W-1:0]  prev_time;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] roll, pitch, throttle, yaw;
      bit                 unlock, headless, hold;
      channel_word_type   expected[$];
      int                 mismatches;
      int                 channels_seen;
      int                 frames_seen;

      function void clear_state();
         threshold = THRESHOLD_RESET;
         have_prev = 0;
         synced = 0;
         prev_time = '0;
         count = '0;
         roll = '0;
         pitch = '0;
         throttle = '0;
         yaw = '0;
         unlock = 0;
         headless = 0;
         hold = 0;
         expected.delete();
         mismatches = 0;
         channels_seen = 0;
         frames_seen = 0;
      endfunction

      function void update_commands(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] v);
         case (idx)
            CH_ROLL: roll = v;
            CH_PITCH: pitch = v;
            CH_THROTTLE: begin
               if (v < THROTTLE_LIMIT)
                  throttle = hold ? HOLD_THROTTLE : v;
            end
            CH_YAW: yaw = v;
            CH_MODE: begin
               if (v >= NORMAL_LO && v <= NORMAL_HI)
                  hold = 0;
               if (v >= HOLD_LO && v <= HOLD_HI) begin
                  hold = 1;
                  unlock = 1;
               end
            end
            CH_UNLOCK: begin
               // unlock only with throttle low, lock unconditionally
               if (v > SWITCH_ON) begin
                  if (throttle < ARM_THROTTLE_MAX)
                     unlock = 1;
               end else begin
                  unlock = 0;
               end
            end
            CH_HEADLESS: headless = (v > SWITCH_ON);
            default: ;
         endcase
      endfunction

      function void note_capture(logic [TIME_W-1:0] t);
         logic [TIME_W-1:0]  gap;
         int unsigned        quot;
         logic [INDEX_W-1:0] idx;
         channel_word_type   w;
         if (!have_prev) begin
            prev_time = t;
            have_prev = 1;
            return;
         end
         gap = t - prev_time;
         prev_time = t;
         if (gap >= threshold)
            synced = 1;
         if (!synced || gap > threshold)
            return;
         quot = 32'(gap) / 32'd6;
         if (quot > 32'(VALUE_MAX))
            quot = 32'(VALUE_MAX);
         idx = count[INDEX_W-1:0];
         update_commands(idx, quot[VALUE_W-1:0]);
         count = count + COUNT_W'(1);
         w.done = (count >= COUNT_W'(NUM_CHANNELS));
         if (w.done) begin
            count = '0;
            prev_time = '0;
            have_prev = 0;
            synced = 0;
         end
         w.chan = idx;
         w.value = quot[VALUE_W-1:0];
         w.roll = roll;
         w.pitch = pitch;
         w.throttle = throttle;
         w.yaw = yaw;
         w.armed = unlock;
         w.headless = headless;
         w.hold = hold;
         expected.push_back(w);
      endfunction

      function void check_channel(logic [RSP_DATA_W-1:0] data, logic last);
         channel_word_type got, want;
         got.chan = data[2:0];
         got.value = data[14:3];
         got.roll = data[26:15];
         got.pitch = data[38:27];
         got.throttle = data[50:39];
         got.yaw = data[62:51];
         got.armed = data[63];
         got.headless = data[64];
         got.hold = data[65];
         got.done = last;
         channels_seen++;
         if (last)
            frames_seen++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected channel word: ch %0d value %0d done %0d",
                        got.chan, got.value, got.done);
            return;
         end
         want = expected.pop_front();
         if (got.chan !== want.chan || got.value !== want.value ||
             got.done !== want.done || got.roll !== want.roll ||
             got.pitch !== want.pitch || got.throttle !== want.throttle ||
             got.yaw !== want.yaw || got.armed !== want.armed ||
             got.headless !== want.headless || got.hold !== want.hold) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("exp: ch %0d val %0d done %0d r %0d p %0d t %0d y %0d a %0d h %0d m %0d",
                        want.chan, want.value, want.done, want.roll, want.pitch,
                        want.throttle, want.yaw, want.armed, want.headless, want.hold);
               $display("got: ch %0d val %0d done %0d r %0d p %0d t %0d y %0d a %0d h %0d m %0d",
                        got.chan, got.value, got.done, got.roll, got.pitch,
                        got.throttle, got.yaw, got.armed, got.headless, got.hold);
            end
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [TIME_W-1:0]       req_tdata = '0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [TIME_W-1:0]       csr_data = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;

   ppm_scoreboard_type board;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int threshold_writes = 0;
   int quiet_cycles = 0;
   int cur_threshold = int'(THRESHOLD_RESET);

   ppm_rc_frame_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_channel(rsp_tdata, rsp_tlast);
   end

   // ends the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d channel words outstanding",
                     board.expected.size());
            $display("ppm_rc_frame_decoder_unit test failed");
            $finish;
         end
      end
   end

   task automatic send_capture(input logic [TIME_W-1:0] t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= t;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_capture(t);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value[TIME_W-1:0];
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      board.threshold = value[TIME_W-1:0];
      cur_threshold = value;
      threshold_writes++;
   endtask

   // channel interval aimed mostly at the band edges of the flight logic
   function automatic int channel_ticks();
      int edges[20] = '{0, 949, 950, 1000, 1050, 1051, 1099, 1100, 1149, 1150,
                        1200, 1250, 1251, 1299, 1300, 1301, 1550, 2019, 2020, 3333};
      int v, ticks;
      if ($urandom_range(0, 99) < 60)
         v = edges[$urandom_range(0, 19)];
      else
         v = $urandom_range(0, 3400);
      ticks = v * 6 + $urandom_range(0, 5);
      if (ticks > cur_threshold)
         ticks = $urandom_range(0, cur_threshold);
      return ticks;
   endfunction

   task automatic send_frame(input int channels, input bit exact_sync);
      logic [TIME_W-1:0] t;
      t = TIME_W'($urandom_range(0, 65535));
      send_capture(t);
      t = t + TIME_W'(exact_sync ? cur_threshold : $urandom_range(cur_threshold, 65535));
      send_capture(t);
      for (int i = 0; i < channels; i++) begin
         t = t + TIME_W'(channel_ticks());
         send_capture(t);
      end
   endtask

   task automatic send_ticks(inout logic [TIME_W-1:0] t, input int gap);
      t = t + TIME_W'(gap);
      send_capture(t);
   endtask

   initial begin
      logic [TIME_W-1:0] t;
      int phase_thresholds[NUM_PHASES];
      int target, pick;
      board = new();
      board.clear_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 69;

      // directed: short gap before any start is ignored, long gap starts the frame
      t = 16'hFFFF;
      send_capture(t);
      send_ticks(t, 100);
      send_ticks(t, 30000);
      send_ticks(t, 0);
      send_ticks(t, 3333 * 6);
      send_ticks(t, 2019 * 6);
      send_ticks(t, 1000 * 6);
      send_ticks(t, 1200 * 6);
      send_ticks(t, 1301 * 6);
      send_ticks(t, 1301 * 6);
      send_ticks(t, 500 * 6);
      // gap equal to the threshold starts a frame and decodes as channel zero
      t = 16'h0000;
      send_capture(t);
      send_ticks(t, 20000);
      send_ticks(t, 1700 * 6);
      send_ticks(t, 1500 * 6);
      send_ticks(t, 1400 * 6);
      send_ticks(t, 1000 * 6);
      send_ticks(t, 1000 * 6);
      send_ticks(t, 1300 * 6);
      send_ticks(t, 42);
      // widest threshold: full-range gap saturates the channel value
      write_threshold(65535);
      t = 16'h0000;
      send_capture(t);
      send_ticks(t, 65535);
      send_ticks(t, 65535);

      phase_thresholds = '{20000, 65535, 1, 12000, $urandom_range(1, 65535), 20000};
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 38;
            recv_idle_pct = 69;
         end else if (phase < 4) begin
            send_idle_pct = 69;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_threshold(phase_thresholds[phase]);
         target = items_sent + RANDOM_ITEMS / NUM_PHASES;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               send_frame(NUM_CHANNELS, $urandom_range(0, 9) == 0);
            end else if (pick < 88) begin
               send_frame($urandom_range(1, NUM_CHANNELS - 1), 0);
               send_capture(TIME_W'($urandom_range(0, 65535)));
            end else begin
               repeat ($urandom_range(1, 5)) send_capture(TIME_W'($urandom_range(0, 65535)));
            end
            if (phase == 0 && items_sent >= target - RANDOM_ITEMS / (2 * NUM_PHASES)
                && items_sent < target - RANDOM_ITEMS / (2 * NUM_PHASES) + 10)
               wait_drained();
         end
      end

      wait_drained();
      $display("sent %0d capture edges over %0d threshold settings (1 to 65535)",
               items_sent, threshold_writes);
      $display("checked %0d channel words and %0d complete frames",
               board.channels_seen, board.frames_seen);
      if (board.mismatches == 0 && board.expected.size() == 0) begin
         $display("ppm_rc_frame_decoder_unit test passed");
      end else begin
         $display("%0d mismatches, %0d channel words missing",
                  board.mismatches, board.expected.size());
         $display("ppm_rc_frame_decoder_unit test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ppmrc_pkg.sv
design/ppm_rc_frame_decoder_unit.sv
test/ppm_rc_frame_decoder_unit_test.sv
